/* src/zass_pkg.sv */
// ----------------------------------------------------------------------------
// zass_pkg - shared types and constants of the zone average servo steering
// Payload structs, controller command and status bundles, divider operand
// selection and the fixed-point constants of the steering arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

package zass_pkg;

  // Input transaction payload
  typedef struct packed {
    logic        sensor_select;
    logic [11:0] distance_mm;
    logic        last_zone;
  } in_t;

  // Output transaction payload
  typedef struct packed {
    logic [11:0] pulse_width_us;
    logic        homed;
    logic [11:0] left_level;
    logic [11:0] right_level;
  } out_t;

  // Shared divider geometry
  localparam int DIV_W = 29;   // dividend and quotient width
  localparam int DSR_W = 13;   // divisor and remainder width
  localparam int CNT_W = 5;    // step counter width, holds DIV_W - 1

  // Steering arithmetic in Q9.8
  localparam logic [16:0] FULL_Q      = 17'd69120;  // 270 degrees
  localparam logic [16:0] HOME_Q      = 17'd34560;  // 135 degrees
  localparam logic [4:0]  PULSE_MUL   = 5'd25;      // 2000 / 69120 = 25 / 32 / 27
  localparam logic [16:0] PULSE_RECIP = 17'd77673;  // ceil(2^21 / 27)
  localparam logic [11:0] PULSE_BASE  = 12'd500;

  // Divider operand selection
  typedef enum logic [1:0] {
    OP_AVG   = 2'd0,
    OP_FRAC  = 2'd1
  } div_op_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    div_start;
    div_op_t div_op;
    logic    store_avg;
    logic    store_home;
    logic    store_frac;
    logic    scale_pulse;
    logic    load_out;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
    logic sum_zero;
    logic out_free;
  } ctrl_stat_t;

endpackage

`default_nettype wire

/* src/zass_div.sv */
// ----------------------------------------------------------------------------
// zass_div - iterative restoring divider
// Produces one quotient bit per cycle; done pulses as the last step is
// registered, and the quotient holds until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module zass_div
  import zass_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DSR_W-1:0] divisor,
  output logic      [DIV_W-1:0] quot,
  output logic                  done
);

  logic [DSR_W-1:0] rem;
  logic [DSR_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DSR_W:0]   shifted;
  logic [DSR_W:0]   diff;
  logic             ge;

  // Form trial subtraction of the next partial remainder
  always_comb begin
    shifted = {rem, quot[DIV_W-1]};
    diff    = shifted - {1'b0, dsr};
    ge      = (shifted >= {1'b0, dsr});
  end

  // Advance one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quot <= dividend;
        rem  <= '0;
        dsr  <= divisor;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        quot <= {quot[DIV_W-2:0], ge};
        rem  <= ge ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
        if (cnt == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* src/zass_datapath.sv */
// ----------------------------------------------------------------------------
// zass_datapath - frame accumulator, levels, angle and output register
// Accumulates zone samples, feeds the shared divider for the frame average
// and the angle fraction, scales the angle to a pulse width by a reciprocal
// multiply, and holds the result transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module zass_datapath
  import zass_pkg::*;
#(
  parameter int MAX_ZONES = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_fire,
  input  wire in_t               in_data,
  input  wire logic              cfg_we,
  input  wire logic signed [7:0] cfg_data,
  input  wire ctrl_cmd_t         cmd,
  output ctrl_stat_t             stat,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_t                   out_data
);

  localparam logic [6:0] ZoneLimit = 7'(MAX_ZONES);

  logic signed [7:0] offset;
  logic [17:0]       zone_sum;
  logic [6:0]        zone_count;
  logic [11:0]       left_avg;
  logic [11:0]       right_avg;
  logic              sel;
  logic [16:0]       angle;
  logic              homed;
  logic [15:0]       pulse_y;

  logic [DIV_W-1:0]  div_dividend;
  logic [DSR_W-1:0]  div_divisor;
  logic [DIV_W-1:0]  quot;
  logic              div_done;

  logic [12:0]       level_sum;
  logic [11:0]       avg_sat;
  logic [18:0]       angle_s;
  logic              out_of_range;
  logic [20:0]       pulse_scaled;
  logic [32:0]       pulse_prod;
  logic [11:0]       pulse_q;

  // Select divider operands for the requested operation
  always_comb begin
    case (cmd.div_op)
      OP_AVG: begin
        div_dividend = {11'b0, zone_sum};
        div_divisor  = {6'b0, zone_count};
      end
      OP_FRAC: begin
        div_dividend = DIV_W'({17'b0, left_avg} * {12'b0, FULL_Q});
        div_divisor  = level_sum;
      end
      default: begin
        div_dividend = '0;
        div_divisor  = '0;
      end
    endcase
  end

  zass_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quot     (quot),
    .done     (div_done)
  );

  // Saturate average, add trim to fraction and range check
  always_comb begin
    level_sum    = {1'b0, left_avg} + {1'b0, right_avg};
    avg_sat      = (|quot[DIV_W-1:12]) ? 12'hFFF : quot[11:0];
    angle_s      = {{3{offset[7]}}, offset, 8'h00} + {2'b00, quot[16:0]};
    out_of_range = angle_s[18] || (angle_s > {2'b00, FULL_Q});
  end

  // Scale angle to pulse: angle * 25 / 864, the final divide by 27 as a
  // reciprocal multiply that is exact below 2^16
  always_comb begin
    pulse_scaled = {4'b0, angle} * {16'b0, PULSE_MUL};
    pulse_prod   = {17'b0, pulse_y} * {16'b0, PULSE_RECIP};
    pulse_q      = pulse_prod[32:21];
  end

  // Report status to the controller
  always_comb begin
    stat.div_done = div_done;
    stat.sum_zero = (level_sum == 13'd0);
    stat.out_free = !out_valid || out_ready;
  end

  // Hold configuration, accumulator and levels
  always_ff @(posedge clk) begin
    if (rst) begin
      offset     <= '0;
      zone_sum   <= '0;
      zone_count <= '0;
      left_avg   <= '0;
      right_avg  <= '0;
    end else begin
      if (cfg_we) begin
        offset <= cfg_data;
      end
      if (in_fire) begin
        sel <= in_data.sensor_select;
        if (zone_count < ZoneLimit) begin
          zone_sum   <= zone_sum + {6'b0, in_data.distance_mm};
          zone_count <= zone_count + 1'b1;
        end
      end else if (cmd.store_avg) begin
        if (sel) begin
          right_avg <= avg_sat;
        end else begin
          left_avg <= avg_sat;
        end
        zone_sum   <= '0;
        zone_count <= '0;
      end
    end
  end

  // Capture steering angle, homing where needed
  always_ff @(posedge clk) begin
    if (cmd.store_home) begin
      angle <= HOME_Q;
      homed <= 1'b1;
    end else if (cmd.store_frac) begin
      if (out_of_range) begin
        angle <= HOME_Q;
        homed <= 1'b1;
      end else begin
        angle <= angle_s[16:0];
        homed <= 1'b0;
      end
    end
  end

  // Register the pulse numerator after the divide by 32
  always_ff @(posedge clk) begin
    if (cmd.scale_pulse) begin
      pulse_y <= pulse_scaled[20:5];
    end
  end

  // Hold the result transaction until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.pulse_width_us <= pulse_q + PULSE_BASE;
      out_data.homed          <= homed;
      out_data.left_level     <= left_avg;
      out_data.right_level    <= right_avg;
    end
  end

endmodule

`default_nettype wire

/* src/zass_ctrl.sv */
// ----------------------------------------------------------------------------
// zass_ctrl - frame close sequencer
// Accepts zone samples while idle and, on the last zone, steps the datapath
// through average, angle fraction or homing, pulse scaling and output load.
// ----------------------------------------------------------------------------
`default_nettype none

module zass_ctrl
  import zass_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       last_zone,
  output logic            in_ready,
  input  wire ctrl_stat_t stat,
  output ctrl_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_AVG_WAIT,
    S_AVG_STORE,
    S_SUM_CHECK,
    S_FRAC_WAIT,
    S_PULSE_GO,
    S_PULSE_WAIT,
    S_LOAD
  } state_t;

  state_t state;

  // Sequence the frame close; command strobes are single-cycle pulses, div_op holds
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b1;
      cmd      <= '0;
    end else begin
      cmd.div_start   <= 1'b0;
      cmd.store_avg   <= 1'b0;
      cmd.store_home  <= 1'b0;
      cmd.store_frac  <= 1'b0;
      cmd.scale_pulse <= 1'b0;
      cmd.load_out    <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready && last_zone) begin
            in_ready      <= 1'b0;
            cmd.div_start <= 1'b1;
            cmd.div_op    <= OP_AVG;
            state         <= S_AVG_WAIT;
          end
        end
        S_AVG_WAIT: begin
          if (stat.div_done) begin
            cmd.store_avg <= 1'b1;
            state         <= S_AVG_STORE;
          end
        end
        // wait for the new level to settle before the sum check
        S_AVG_STORE: begin
          state <= S_SUM_CHECK;
        end
        S_SUM_CHECK: begin
          if (stat.sum_zero) begin
            cmd.store_home <= 1'b1;
            state          <= S_PULSE_GO;
          end else begin
            cmd.div_start <= 1'b1;
            cmd.div_op    <= OP_FRAC;
            state         <= S_FRAC_WAIT;
          end
        end
        S_FRAC_WAIT: begin
          if (stat.div_done) begin
            cmd.store_frac <= 1'b1;
            state          <= S_PULSE_GO;
          end
        end
        S_PULSE_GO: begin
          cmd.scale_pulse <= 1'b1;
          state           <= S_PULSE_WAIT;
        end
        S_PULSE_WAIT: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (stat.out_free) begin
            cmd.load_out <= 1'b1;
            in_ready     <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          in_ready <= 1'b1;
          state    <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/zone_average_servo_steering.sv */
// ----------------------------------------------------------------------------
// zone_average_servo_steering - zone averaging servo steering top level
// Averages ranging sensor zone frames per side and turns the left share of
// the two levels into a servo pulse width, homing to center when invalid.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------
//  in      | input     | in_valid / in_ready | in_data (in_t)
//  out     | output    | out_valid/out_ready | out_data (out_t)
//  cfg     | input     | cfg_we, no wait     | cfg_data (angle offset)
//
//  A zone sample that is not the last of its frame is taken without dropping
//  in_ready. A last-zone sample holds in_ready low through two passes of the
//  shared 29-step divider (frame average, angle fraction), sequencing and a
//  registered reciprocal pulse scaling; a zero level sum skips the fraction
//  pass. out_valid rises in the cycle after in_ready returns high. Reset
//  is synchronous and clears levels, accumulator and offset. A result waiting
//  in the output register only blocks the final load of the next frame close.
// ----------------------------------------------------------------------------
`default_nettype none

module zone_average_servo_steering
  import zass_pkg::*;
#(
  parameter int MAX_ZONES = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_t               in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_t                   out_data,
  input  wire logic              cfg_we,
  input  wire logic signed [7:0] cfg_data
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;
  logic       in_fire;

  assign in_fire = in_valid && in_ready;

  zass_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_zone (in_data.last_zone),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  zass_datapath #(
    .MAX_ZONES (MAX_ZONES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
